// File: design/lsbsd_pkg.sv
// shared types and constants for the lsb steganography stream decoder
// used by lsbsd_core and lsb_stego_stream_decoder; no dependencies
package lsbsd_pkg;

    // decode phases of one carrier frame
    typedef enum logic [2:0]
    {
        PH_HEADER  = 3'd0,
        PH_MAGIC   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_EXT     = 3'd3,
        PH_PAYLEN  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6
    } phase_t;

    // result kinds carried on the output tuser
    typedef enum logic [2:0]
    {
        KIND_EXT       = 3'd0,
        KIND_PAYLOAD   = 3'd1,
        KIND_MAGIC_ERR = 3'd2,
        KIND_EXT_LONG  = 3'd3,
        KIND_EMPTY     = 3'd4
    } kind_t;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND  = 2'd2;

    // configuration reset values
    localparam logic [7:0] HEADER_LENGTH_RST = 8'd54;
    localparam logic [7:0] MAGIC_FIRST_RST   = 8'd35;
    localparam logic [7:0] MAGIC_SECOND_RST  = 8'd42;

    // one decoded result
    typedef struct packed
    {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } result_t;

endpackage

// File: design/lsbsd_core.sv
// frame decode state and per-byte next-state logic of the lsb stego decoder
// depends on lsbsd_pkg
module lsbsd_core #(
    parameter int unsigned MAX_EXTENSION = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              image_bit,
    input  logic              frame_start,
    input  logic [7:0]        header_length,
    input  logic [7:0]        magic_first,
    input  logic [7:0]        magic_second,
    output logic              emit,
    output lsbsd_pkg::result_t result
);
    import lsbsd_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  hc_reg,     hc_next;
    logic [4:0]  bc_reg,     bc_next;
    logic [31:0] sh_reg,     sh_next;
    logic        mi_reg,     mi_next;
    logic [30:0] items_reg,  items_next;

    // state as seen after an optional frame restart
    phase_t      phase_eff;
    logic [7:0]  hc_eff;
    logic [4:0]  bc_eff;
    logic [31:0] sh_eff;
    logic        mi_eff;
    logic [30:0] items_eff;

    phase_t      work_phase;
    logic        header_hold;
    logic [31:0] shift_new;
    logic [4:0]  bc_new;
    logic        done8;
    logic        done32;
    logic [30:0] len_val;
    logic        ext_long;
    logic [30:0] items_dec;
    logic        magic_ok;

    always_comb
    begin
        phase_eff = frame_start ? PH_HEADER : phase_reg;
        hc_eff    = frame_start ? 8'd0  : hc_reg;
        bc_eff    = frame_start ? 5'd0  : bc_reg;
        sh_eff    = frame_start ? 32'd0 : sh_reg;
        mi_eff    = frame_start ? 1'b0  : mi_reg;
        items_eff = frame_start ? 31'd0 : items_reg;
    end

    assign header_hold = (phase_eff == PH_HEADER) && (hc_eff < header_length);
    assign work_phase  = (phase_eff == PH_HEADER) ? PH_MAGIC : phase_eff;
    assign shift_new   = {sh_eff[30:0], image_bit};
    assign bc_new      = bc_eff + 5'd1;
    assign done8       = (bc_new == 5'd8);
    // 32 bits gathered wraps the 5-bit count back to zero
    assign done32      = (bc_new == 5'd0);
    // lengths with the top bit set count as zero
    assign len_val     = shift_new[31] ? 31'd0 : shift_new[30:0];
    assign ext_long    = (len_val > 31'(MAX_EXTENSION));
    assign items_dec   = (items_eff != 31'd0) ? (items_eff - 31'd1) : 31'd0;
    assign magic_ok    = (shift_new[7:0] == (mi_eff ? magic_second : magic_first));

    // next state
    always_comb
    begin
        phase_next = phase_eff;
        hc_next    = hc_eff;
        bc_next    = bc_eff;
        sh_next    = sh_eff;
        mi_next    = mi_eff;
        items_next = items_eff;
        if (header_hold)
        begin
            hc_next = hc_eff + 8'd1;
        end
        else
        begin
            phase_next = work_phase;
            unique case (work_phase)
                PH_MAGIC:
                begin
                    bc_next = done8 ? 5'd0 : bc_new;
                    sh_next = done8 ? 32'd0 : shift_new;
                    if (done8)
                    begin
                        if (!magic_ok)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (mi_eff)
                        begin
                            mi_next    = 1'b0;
                            phase_next = PH_EXTLEN;
                        end
                        else
                        begin
                            mi_next = 1'b1;
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    bc_next = bc_new;
                    sh_next = done32 ? 32'd0 : shift_new;
                    if (done32)
                    begin
                        if (ext_long)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            items_next = len_val;
                            phase_next = (len_val != 31'd0) ? PH_EXT : PH_PAYLEN;
                        end
                    end
                end
                PH_EXT:
                begin
                    bc_next = done8 ? 5'd0 : bc_new;
                    sh_next = done8 ? 32'd0 : shift_new;
                    if (done8)
                    begin
                        items_next = items_dec;
                        if (items_dec == 31'd0)
                        begin
                            phase_next = PH_PAYLEN;
                        end
                    end
                end
                PH_PAYLEN:
                begin
                    bc_next = bc_new;
                    sh_next = done32 ? 32'd0 : shift_new;
                    if (done32)
                    begin
                        if (len_val == 31'd0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            items_next = len_val;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    bc_next = done8 ? 5'd0 : bc_new;
                    sh_next = done8 ? 32'd0 : shift_new;
                    if (done8)
                    begin
                        items_next = items_dec;
                        if (items_dec == 31'd0)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        emit            = 1'b0;
        result.out_byte = 8'd0;
        result.kind     = KIND_EXT;
        result.last     = 1'b0;
        if (!header_hold)
        begin
            unique case (work_phase)
                PH_MAGIC:
                begin
                    emit        = done8 && !magic_ok;
                    result.kind = KIND_MAGIC_ERR;
                    result.last = 1'b1;
                end
                PH_EXTLEN:
                begin
                    emit        = done32 && ext_long;
                    result.kind = KIND_EXT_LONG;
                    result.last = 1'b1;
                end
                PH_EXT:
                begin
                    emit            = done8;
                    result.out_byte = shift_new[7:0];
                    result.kind     = KIND_EXT;
                end
                PH_PAYLEN:
                begin
                    emit        = done32 && (len_val == 31'd0);
                    result.kind = KIND_EMPTY;
                    result.last = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    emit            = done8;
                    result.out_byte = shift_new[7:0];
                    result.kind     = KIND_PAYLOAD;
                    result.last     = (items_dec == 31'd0);
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hc_reg    <= 8'd0;
            bc_reg    <= 5'd0;
            sh_reg    <= 32'd0;
            mi_reg    <= 1'b0;
            items_reg <= 31'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            bc_reg    <= bc_next;
            sh_reg    <= sh_next;
            mi_reg    <= mi_next;
            items_reg <= items_next;
        end
    end

    // a finished frame stays finished until a restart
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) && !(step && frame_start) |=> (phase_reg == PH_DONE))
        else $error("decoder left the done phase without a frame restart");

    // byte phases never hold more than seven gathered bits
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MAGIC || phase_reg == PH_EXT || phase_reg == PH_PAYLOAD)
        |-> (bc_reg < 5'd8))
        else $error("bit count out of range in a byte phase");

    // error and empty results always close the frame
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit && (result.kind == KIND_MAGIC_ERR || result.kind == KIND_EXT_LONG
                         || result.kind == KIND_EMPTY)
        |=> (phase_reg == PH_DONE))
        else $error("terminating result did not end the frame");

endmodule

// File: design/lsb_stego_stream_decoder.sv
// top level of the lsb steganography stream decoder: stream ports, config
// registers, input stage and output stage; depends on lsbsd_pkg, lsbsd_core
//
// usage
//   s_axis carries one carrier image byte per request in tdata; only bit 0
//   holds hidden data. tuser set marks the first byte of a new image and
//   restarts decode. m_axis carries one decoded result per request: tdata is
//   the decoded byte, tuser the result kind, tlast closes the record (final
//   payload byte, magic mismatch, overlong extension or empty payload).
//   cfg_we/cfg_index/cfg_data write header_length, magic_first and
//   magic_second; write them only while the block is idle.
// pipeline and throughput
//   a request taken on s_axis goes through the input register, the decode
//   logic and the output register to m_axis; one request per cycle is
//   sustained while m_axis is not held, set by the single input and output registers.
// reset
//   rst_n clears both stages and restarts decode at the header skip; the
//   registers return to 54, 35 and 42.
// stall
//   while m_axis is held, the output register keeps its result and one more
//   request may wait in the input register; s_axis_tready then drops.
module lsb_stego_stream_decoder #(
    parameter int unsigned MAX_EXTENSION = 9
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [7:0] image_byte
    input  logic                               s_axis_tuser,  // [0] frame_start
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // [7:0] out_byte
    output logic [2:0]                         m_axis_tuser,  // [2:0] kind
    output logic                               m_axis_tlast,  // last
    // configuration write port
    input  logic                               cfg_we,
    input  logic [lsbsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                         cfg_data
);
    import lsbsd_pkg::*;

    // configuration registers
    logic [7:0] header_length_reg;
    logic [7:0] magic_first_reg;
    logic [7:0] magic_second_reg;

    // input stage: only the data bit and the restart flag are needed
    logic    in_valid_reg;
    logic    in_bit_reg;
    logic    in_start_reg;

    // output stage
    logic    out_valid_reg;
    result_t out_result_reg;

    logic    out_free;
    logic    advance;
    logic    core_emit;
    result_t core_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_length_reg <= HEADER_LENGTH_RST;
            magic_first_reg   <= MAGIC_FIRST_RST;
            magic_second_reg  <= MAGIC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER_LENGTH: header_length_reg <= cfg_data;
                REG_MAGIC_FIRST:   magic_first_reg   <= cfg_data;
                REG_MAGIC_SECOND:  magic_second_reg  <= cfg_data;
                default:           ;  // unmapped index, write dropped
            endcase
        end
    end

    // output register can take a new result when empty or being drained
    assign out_free      = !out_valid_reg || m_axis_tready;
    // the buffered input moves through decode whenever the output can take it
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_bit_reg   <= s_axis_tdata[0];
            in_start_reg <= s_axis_tuser;
        end
    end

    lsbsd_core #(
        .MAX_EXTENSION (MAX_EXTENSION)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .image_bit     (in_bit_reg),
        .frame_start   (in_start_reg),
        .header_length (header_length_reg),
        .magic_first   (magic_first_reg),
        .magic_second  (magic_second_reg),
        .emit          (core_emit),
        .result        (core_result)
    );

    // items that produce no result simply leave the output stage empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && core_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_emit)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg.out_byte;
    assign m_axis_tuser  = out_result_reg.kind;
    assign m_axis_tlast  = out_result_reg.last;

endmodule

// File: dv/lsb_stego_stream_decoder_test.sv
// self-checking testbench for lsb_stego_stream_decoder: carrier frames in, hidden records out
// holds its own bit-level decode model inside a small scoreboard class
// depends on lsbsd_pkg and the lsb_stego_stream_decoder rtl
`timescale 1ns / 1ps

module lsb_stego_stream_decoder_test;

    import lsbsd_pkg::*;

    localparam int MAX_EXTENSION = 9;
    // generous cap on the whole run, far above the slowest legal schedule
    localparam int CYCLE_LIMIT = 500000;

    // tracks the decode of the carrier stream and holds the results still owed
    class stego_scoreboard;
        logic [7:0]  header_length;
        logic [7:0]  magic_first;
        logic [7:0]  magic_second;

        phase_t      phase;
        logic [7:0]  header_count;
        logic [4:0]  bit_count;
        logic [31:0] bit_shifter;
        logic        magic_index;
        logic [31:0] items_left;

        result_t     recovered[$];
        int unsigned errors;
        int unsigned results_seen;
        int unsigned busy_items;

        function new();
            header_length = HEADER_LENGTH_RST;
            magic_first   = MAGIC_FIRST_RST;
            magic_second  = MAGIC_SECOND_RST;
            errors        = 0;
            results_seen  = 0;
            busy_items    = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase        = PH_HEADER;
            header_count = '0;
            bit_count    = '0;
            bit_shifter  = '0;
            magic_index  = 1'b0;
            items_left   = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                REG_HEADER_LENGTH: header_length = val;
                REG_MAGIC_FIRST:   magic_first   = val;
                REG_MAGIC_SECOND:  magic_second  = val;
                default: ;
            endcase
        endfunction

        // shift one bit in, msb first; true once need bits are gathered (need 32 wraps to 0)
        function bit shift_in(logic b, int need);
            bit_shifter = {bit_shifter[30:0], b};
            bit_count   = bit_count + 5'd1;
            if (bit_count == need[4:0])
            begin
                bit_count = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // length words with the top bit set count as zero
        function logic [31:0] length_word();
            logic [31:0] v;
            v = bit_shifter;
            bit_shifter = '0;
            if (v[31])
                v = '0;
            return v;
        endfunction

        function void post_result(logic [7:0] b, kind_t k, logic l);
            result_t r;
            r.out_byte = b;
            r.kind     = k;
            r.last     = l;
            recovered.push_back(r);
        endfunction

        // one accepted carrier byte: advance the decode, queue any result it completes
        function void take_carrier_byte(logic [7:0] pixel, logic frame_start);
            logic        b;
            logic [7:0]  byte_v;
            logic [31:0] len;
            b = pixel[0];
            if (frame_start)
                clear_frame();
            // a finished frame ignores everything until the next frame start
            if (phase == PH_DONE)
                return;
            busy_items++;
            if (phase == PH_HEADER)
            begin
                if (header_count < header_length)
                begin
                    header_count = header_count + 8'd1;
                    return;
                end
                phase = PH_MAGIC;
            end
            case (phase)
                PH_MAGIC:
                begin
                    if (shift_in(b, 8))
                    begin
                        byte_v = bit_shifter[7:0];
                        bit_shifter = '0;
                        if (byte_v != (magic_index ? magic_second : magic_first))
                        begin
                            phase = PH_DONE;
                            post_result(8'd0, KIND_MAGIC_ERR, 1'b1);
                        end
                        else if (magic_index)
                        begin
                            magic_index = 1'b0;
                            phase = PH_EXTLEN;
                        end
                        else
                            magic_index = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    if (shift_in(b, 32))
                    begin
                        len = length_word();
                        if (len > MAX_EXTENSION)
                        begin
                            phase = PH_DONE;
                            post_result(8'd0, KIND_EXT_LONG, 1'b1);
                        end
                        else
                        begin
                            items_left = len;
                            phase = (len != 0) ? PH_EXT : PH_PAYLEN;
                        end
                    end
                end
                PH_EXT:
                begin
                    if (shift_in(b, 8))
                    begin
                        byte_v = bit_shifter[7:0];
                        bit_shifter = '0;
                        if (items_left > 0)
                            items_left--;
                        if (items_left == 0)
                            phase = PH_PAYLEN;
                        post_result(byte_v, KIND_EXT, 1'b0);
                    end
                end
                PH_PAYLEN:
                begin
                    if (shift_in(b, 32))
                    begin
                        len = length_word();
                        if (len == 0)
                        begin
                            phase = PH_DONE;
                            post_result(8'd0, KIND_EMPTY, 1'b1);
                        end
                        else
                        begin
                            items_left = len;
                            phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (shift_in(b, 8))
                    begin
                        byte_v = bit_shifter[7:0];
                        bit_shifter = '0;
                        if (items_left > 0)
                            items_left--;
                        if (items_left == 0)
                        begin
                            phase = PH_DONE;
                            post_result(byte_v, KIND_PAYLOAD, 1'b1);
                        end
                        else
                            post_result(byte_v, KIND_PAYLOAD, 1'b0);
                    end
                end
                default: phase = PH_DONE;
            endcase
        endfunction

        // one accepted result against the oldest one owed
        function void check_decoded(logic [7:0] out_byte, logic [2:0] kind, logic last);
            result_t exp_r;
            results_seen++;
            if (recovered.size() == 0)
            begin
                $error("result with nothing owed: out_byte %0d kind %0d last %0d",
                       out_byte, kind, last);
                errors++;
                return;
            end
            exp_r = recovered.pop_front();
            if (exp_r.out_byte !== out_byte)
            begin
                $error("out_byte mismatch: expected %0d, actual %0d", exp_r.out_byte, out_byte);
                errors++;
            end
            if (exp_r.kind !== kind)
            begin
                $error("kind mismatch: expected %0d, actual %0d", exp_r.kind, kind);
                errors++;
            end
            if (exp_r.last !== last)
            begin
                $error("last mismatch: expected %0d, actual %0d", exp_r.last, last);
                errors++;
            end
        endfunction
    endclass

    // one carrier byte waiting to be sent
    typedef struct
    {
        logic [7:0] pixel;
        logic       start;
    } carrier_item_t;

    logic clk;
    logic rst_n;

    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] image_byte
    logic                 s_axis_tuser;   // [0] frame_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // [7:0] out_byte
    logic [2:0]           m_axis_tuser;   // [2:0] kind
    logic                 m_axis_tlast;   // last
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    stego_scoreboard sb;
    carrier_item_t   carrier_q[$];
    logic            start_pending;

    // idling knobs, percent of cycles
    int send_gap_pct;
    int stall_pct;
    // long receiver hold-off, counted down by the receiver process
    int hold_cycles;
    int cycle_count;

    lsb_stego_stream_decoder #(
        .MAX_EXTENSION (MAX_EXTENSION)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // monitor: result check first, then the accepted request, so a result is
    // never matched against an item taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_decoded(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.take_carrier_byte(s_axis_tdata, s_axis_tuser);
        end
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready = 1'b0;
                hold_cycles--;
            end
            else
                m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic set_idling(int mode);
        case (mode)
            0:       begin send_gap_pct = 0;  stall_pct = 0;  end
            1:       begin send_gap_pct = 55; stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  stall_pct = 55; end
            default: begin send_gap_pct = 26; stall_pct = 26; end
        endcase
    endtask

    // register write while the block is idle; the model follows after the edge
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_register(idx, val);
    endtask

    task automatic write_all(logic [7:0] hdr, logic [7:0] m1, logic [7:0] m2);
        write_register(REG_HEADER_LENGTH, hdr);
        write_register(REG_MAGIC_FIRST, m1);
        write_register(REG_MAGIC_SECOND, m2);
    endtask

    // one carrier byte with the given data bit; random upper bits
    task automatic push_pixel(logic lsb);
        carrier_item_t item;
        item.pixel = {7'($urandom), lsb};
        item.start = start_pending;
        start_pending = 1'b0;
        carrier_q.push_back(item);
    endtask

    task automatic push_bits(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            push_pixel(v[i]);
    endtask

    // a whole hidden record behind the current header; fill < 0 means random data
    task automatic build_frame(logic [7:0] m1, logic [7:0] m2, logic [31:0] ext_len,
                               int ext_cnt, logic [31:0] pay_len, int pay_cnt, int fill);
        start_pending = 1'b1;
        for (int i = 0; i < sb.header_length; i++)
            push_pixel(1'($urandom));
        push_bits(32'(m1), 8);
        push_bits(32'(m2), 8);
        push_bits(ext_len, 32);
        for (int i = 0; i < ext_cnt; i++)
            push_bits((fill < 0) ? 32'($urandom_range(0, 255)) : 32'(fill), 8);
        push_bits(pay_len, 32);
        for (int i = 0; i < pay_cnt; i++)
            push_bits((fill < 0) ? 32'($urandom_range(0, 255)) : 32'(fill), 8);
    endtask

    // mostly well-formed records, some broken, truncated or plain noise
    task automatic random_frame();
        int          w;
        int          ext_cnt;
        int          pay_cnt;
        int          n0;
        int          cut;
        logic [7:0]  m1;
        logic [7:0]  m2;
        logic [31:0] ext_len;
        logic [31:0] pay_len;
        w  = $urandom_range(0, 99);
        m1 = sb.magic_first;
        m2 = sb.magic_second;
        ext_cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_EXTENSION)
                                              : $urandom_range(0, 3);
        pay_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        ext_len = ext_cnt;
        pay_len = pay_cnt;
        if (w < 6)
        begin
            // noise, now and then restarting a frame
            repeat ($urandom_range(4, 30))
            begin
                start_pending = ($urandom_range(0, 7) == 0);
                push_pixel(1'($urandom));
            end
            return;
        end
        if (w < 14)
        begin
            // top bit set on the extension length: no extension bytes
            ext_len = {1'b1, 31'($urandom)};
            ext_cnt = 0;
        end
        else if (w < 22)
        begin
            if ($urandom_range(0, 1))
                m1 = m1 ^ 8'($urandom_range(1, 255));
            else
                m2 = m2 ^ 8'($urandom_range(1, 255));
        end
        else if (w < 30)
        begin
            ext_len = ($urandom_range(0, 1)) ? 32'($urandom_range(MAX_EXTENSION + 1, 40))
                                             : {1'b0, 31'($urandom)};
            if (ext_len <= MAX_EXTENSION)
                ext_len = MAX_EXTENSION + 1;
            ext_cnt = $urandom_range(0, 2);
        end
        else if (w < 38)
        begin
            pay_len = ($urandom_range(0, 1)) ? 32'd0 : {1'b1, 31'($urandom)};
            pay_cnt = $urandom_range(0, 2);
        end
        n0 = carrier_q.size();
        build_frame(m1, m2, ext_len, ext_cnt, pay_len, pay_cnt, -1);
        if (w >= 38 && w < 44)
        begin
            // cut short; the next frame start restarts decode
            cut = $urandom_range(1, carrier_q.size() - n0 - 1);
            repeat (cut)
                void'(carrier_q.pop_back());
        end
        if ($urandom_range(0, 3) == 0)
        begin
            // trailing bytes with no frame start
            repeat ($urandom_range(1, 8))
                push_pixel(1'($urandom));
        end
    endtask

    // sender: one request per iteration, or a gap cycle
    task automatic send_carrier();
        carrier_item_t item;
        while (carrier_q.size() != 0)
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < send_gap_pct)
                s_axis_tvalid = 1'b0;
            else
            begin
                item = carrier_q.pop_front();
                s_axis_tvalid = 1'b1;
                s_axis_tdata  = item.pixel;
                s_axis_tuser  = item.start;
                @(posedge clk);
                while (!s_axis_tready)
                    @(posedge clk);
            end
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // wait until every owed result came, then let the pipeline empty
    task automatic wait_drained();
        @(negedge clk);
        while (sb.recovered.size() != 0)
            @(negedge clk);
        repeat (6)
            @(negedge clk);
    endtask

    initial
    begin
        int          p;
        int          frames;
        logic [7:0]  hdr;
        sb = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_HEADER_LENGTH;
        cfg_data      = 8'd0;
        start_pending = 1'b0;
        hold_cycles   = 0;
        cycle_count   = 0;
        set_idling(0);

        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        // register reset values: default header skip and magic bytes
        build_frame(sb.magic_first, sb.magic_second, 32'd1, 1, 32'd2, 2, -1);
        send_carrier();
        wait_drained();

        // directed records with no header: first byte of a frame is data
        write_all(8'd0, 8'h00, 8'hFF);
        build_frame(sb.magic_first, sb.magic_second, 32'd0, 0, 32'd1, 1, 8'h00);
        build_frame(sb.magic_first, sb.magic_second, MAX_EXTENSION, MAX_EXTENSION,
                    32'd3, 3, 8'hFF);
        build_frame(8'h01, sb.magic_second, 32'd1, 1, 32'd1, 1, -1);
        build_frame(sb.magic_first, 8'h7F, 32'd1, 1, 32'd1, 1, -1);
        build_frame(sb.magic_first, sb.magic_second, MAX_EXTENSION + 1, 0, 32'd1, 1, -1);
        build_frame(sb.magic_first, sb.magic_second, 32'h8000_0005, 0, 32'd2, 2, -1);
        build_frame(sb.magic_first, sb.magic_second, 32'h7FFF_FFFF, 0, 32'd1, 1, -1);
        build_frame(sb.magic_first, sb.magic_second, 32'hFFFF_FFFF, 0, 32'd1, 1, -1);
        build_frame(sb.magic_first, sb.magic_second, 32'd2, 2, 32'd0, 0, -1);
        // bytes after a finished frame are ignored
        repeat (6)
            push_pixel(1'($urandom));
        build_frame(sb.magic_first, sb.magic_second, 32'd1, 1, 32'hFFFF_FFFF, 0, -1);
        // restart in the middle of the payload
        build_frame(sb.magic_first, sb.magic_second, 32'd1, 1, 32'd2, 2, -1);
        repeat (12)
            void'(carrier_q.pop_back());
        build_frame(sb.magic_first, sb.magic_second, 32'd1, 1, 32'd1, 1, -1);
        send_carrier();
        wait_drained();

        // random phases, each with its own register setting and idling
        p = 0;
        while ((sb.busy_items < 1200 || sb.results_seen < 60 || p < 5) && p < 80)
        begin
            case (p)
                0: write_all(8'd255, 8'hFF, 8'h00);
                1: write_all(8'd0, 8'h00, 8'hFF);
                2: write_all(8'd1, 8'hA5, 8'h5A);
                3: write_all(8'd3, MAGIC_FIRST_RST, MAGIC_SECOND_RST);
                4: write_all(8'd2, 8'($urandom), 8'($urandom));
                default:
                begin
                    hdr = (p % 7 == 6) ? 8'($urandom_range(13, 254)) : 8'($urandom_range(0, 12));
                    write_all(hdr, 8'($urandom), 8'($urandom));
                end
            endcase
            set_idling(p % 4);
            // one frame per phase, two while the receiver holds off
            frames = (p == 4) ? 2 : 1;
            repeat (frames)
                random_frame();
            if (p == 4)
            begin
                // receiver holds off while the sender keeps offering requests
                @(posedge clk);
                hold_cycles = 400;
            end
            send_carrier();
            wait_drained();
            p++;
        end

        wait_drained();
        repeat (10)
            @(negedge clk);
        if (sb.recovered.size() != 0)
            $error("%0d results still owed at the end", sb.recovered.size());
        if (sb.errors == 0 && sb.recovered.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
